[sv/idle_delimited_frame_receiver_macros.svh]
// assertion macros for the idle delimited frame receiver
// needs clk and rst_n in the scope of the module that uses them
`ifndef IDLE_DELIMITED_FRAME_RECEIVER_MACROS_SVH
`define IDLE_DELIMITED_FRAME_RECEIVER_MACROS_SVH

// checked only outside reset
`define IDFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define IDFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/idfr_pkg.sv]
// constants and codes for the idle delimited frame receiver
// no dependencies
package idfr_pkg;

  localparam int ZONES        = 4;
  localparam int BUFFER_DEPTH = 16;
  localparam int SUM_LEN      = 10;
  localparam int SUM_POS      = 10;
  localparam int REC_FIRST    = 1;
  localparam int REC_LAST     = 9;
  // only bytes up to the checksum position are ever read back
  localparam int KEEP_DEPTH   = SUM_POS + 1;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int LOST_W       = 4;
  localparam int ZONE_OUT_W   = 2;
  localparam int PERIOD_W     = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;
  localparam logic [7:0]          DELIM_RESET  = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER_BYTE  = 1'b1;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_PACKET   = 3'd1,
    EV_MISMATCH = 3'd2,
    EV_RANGE    = 3'd3,
    EV_WATCHDOG = 3'd4
  } ev_code_t;

endpackage

[sv/idle_delimited_frame_receiver.sv]
// idle delimited frame receiver: byte framing, checksum, zone watchdog
// depends on idfr_pkg and idle_delimited_frame_receiver_macros.svh
//
//  channel | signals                                  | role
//  --------+------------------------------------------+-----------------------------
//  in      | in_valid/in_ready, in_op, in_rx_byte     | byte or timer tick request
//  out     | out_valid/out_ready, out_event_res, ...  | one result per request
//  cfg     | cfg_we, cfg_index, cfg_wdata             | watchdog period, delimiter
//
// one request is taken per cycle unless a result waits with out_ready low; its result
// sits in the output register the cycle after acceptance
// the whole update (checksum adder tree, zone check, watchdog compare) is
// one combinational pass from the state registers to the result register
// in_ready is low only while a result waits and out_ready is low
// rst_n is synchronous: buffer, index, alive marks and tick count clear
`include "idle_delimited_frame_receiver_macros.svh"

module idle_delimited_frame_receiver (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_op,
  input  logic [7:0]                         in_rx_byte,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         out_event_res,
  output logic [idfr_pkg::ZONE_OUT_W-1:0]    out_zone,
  output logic [7:0]                         out_mode_flags,
  output logic [7:0]                         out_flag_r,
  output logic [7:0]                         out_flag_e,
  output logic [7:0]                         out_phase,
  output logic [7:0]                         out_regen_work_enable,
  output logic [7:0]                         out_regen_error,
  output logic [7:0]                         out_current,
  output logic [7:0]                         out_voltage,
  output logic [7:0]                         out_spark_count,
  output logic [idfr_pkg::LOST_W-1:0]        out_lost_zones,
  // configuration
  input  logic                               cfg_we,
  input  logic [idfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [idfr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  typedef struct packed {
    idfr_pkg::ev_code_t                ev;
    logic [idfr_pkg::ZONE_OUT_W-1:0]   zone;
    logic [idfr_pkg::REC_LAST:idfr_pkg::REC_FIRST][7:0] rec;
    logic [idfr_pkg::LOST_W-1:0]       lost;
  } result_t;

  // state
  logic [7:0]                      buf_r   [idfr_pkg::KEEP_DEPTH];
  logic [7:0]                      buf_nxt [idfr_pkg::KEEP_DEPTH];
  logic [idfr_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic                            pause_r, pause_nxt;
  logic [idfr_pkg::ZONES-1:0]      alive_r, alive_nxt;
  logic [idfr_pkg::PERIOD_W-1:0]   tick_r, tick_nxt;
  logic [idfr_pkg::PERIOD_W-1:0]   period_r;
  logic [7:0]                      delim_r;

  // output register
  logic                            out_valid_r;
  result_t                         res_r, res_nxt;

  logic                            accept;
  logic [7:0]                      sum;
  logic [3:0]                      nib;
  logic                            zone_ok;
  logic                            wd_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // additive checksum over the leading bytes, mod 256
  always_comb begin
    sum = '0;
    for (int k = 0; k < idfr_pkg::SUM_LEN; k++) begin
      sum = sum + buf_r[k];
    end
  end

  // zone number sits one above its index in the high nibble of byte 0
  assign nib     = buf_r[0][7:4];
  assign zone_ok = (nib != 4'd0) && ({28'd0, nib} <= 32'(idfr_pkg::ZONES));
  assign wd_fire = (tick_r >= period_r);

  always_comb begin
    buf_nxt   = buf_r;
    idx_nxt   = idx_r;
    pause_nxt = pause_r;
    alive_nxt = alive_r;
    tick_nxt  = tick_r;
    res_nxt   = '0;
    res_nxt.ev = idfr_pkg::EV_NONE;
    if (accept) begin
      if (in_op == idfr_pkg::OP_TICK) begin
        if (wd_fire) begin
          // period elapsed: report silent zones and start a new period
          tick_nxt     = '0;
          res_nxt.ev   = idfr_pkg::EV_WATCHDOG;
          res_nxt.lost = idfr_pkg::LOST_W'(~alive_r);
          alive_nxt    = '0;
        end else begin
          tick_nxt = tick_r + 1'b1;
        end
      end else if (in_rx_byte != delim_r) begin
        pause_nxt = 1'b0;
        // a full buffer drops the byte and holds the index
        if (idx_r < idfr_pkg::IDX_W'(idfr_pkg::BUFFER_DEPTH)) begin
          for (int i = 0; i < idfr_pkg::KEEP_DEPTH; i++) begin
            if (idx_r == idfr_pkg::IDX_W'(i)) begin
              buf_nxt[i] = in_rx_byte;
            end
          end
          idx_nxt = idx_r + 1'b1;
        end
      end else if (!pause_r) begin
        // first delimiter after data or reset closes the packet; stale bytes stay
        pause_nxt = 1'b1;
        idx_nxt   = '0;
        priority if (sum != buf_r[idfr_pkg::SUM_POS]) begin
          res_nxt.ev = idfr_pkg::EV_MISMATCH;
        end else if (!zone_ok) begin
          res_nxt.ev = idfr_pkg::EV_RANGE;
        end else begin
          res_nxt.ev   = idfr_pkg::EV_PACKET;
          res_nxt.zone = idfr_pkg::ZONE_OUT_W'(nib - 4'd1);
          for (int z = 0; z < idfr_pkg::ZONES; z++) begin
            if ({28'd0, nib} == 32'(z + 1)) begin
              alive_nxt[z] = 1'b1;
            end
          end
          for (int k = idfr_pkg::REC_FIRST; k <= idfr_pkg::REC_LAST; k++) begin
            res_nxt.rec[k] = buf_r[k];
          end
        end
      end
      // a repeated delimiter falls through with nothing to report
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < idfr_pkg::KEEP_DEPTH; i++) begin
        buf_r[i] <= '0;
      end
      idx_r       <= '0;
      pause_r     <= 1'b0;
      alive_r     <= '0;
      tick_r      <= '0;
      period_r    <= idfr_pkg::PERIOD_RESET;
      delim_r     <= idfr_pkg::DELIM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      buf_r   <= buf_nxt;
      idx_r   <= idx_nxt;
      pause_r <= pause_nxt;
      alive_r <= alive_nxt;
      tick_r  <= tick_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          idfr_pkg::CFG_WATCHDOG_PERIOD: period_r <= cfg_wdata;
          idfr_pkg::CFG_DELIMITER_BYTE:  delim_r  <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload register, loaded on each accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_event_res         = res_r.ev;
  assign out_zone              = res_r.zone;
  assign out_mode_flags        = res_r.rec[1];
  assign out_flag_r            = res_r.rec[2];
  assign out_flag_e            = res_r.rec[3];
  assign out_phase             = res_r.rec[4];
  assign out_regen_work_enable = res_r.rec[5];
  assign out_regen_error       = res_r.rec[6];
  assign out_current           = res_r.rec[7];
  assign out_voltage           = res_r.rec[8];
  assign out_spark_count       = res_r.rec[9];
  assign out_lost_zones        = res_r.lost;

  `IDFR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r, "result pending after reset")
  `IDFR_ASSERT(a_idx_bound, idx_r <= idfr_pkg::IDX_W'(idfr_pkg::BUFFER_DEPTH), "index past buffer")
  `IDFR_ASSERT(a_lost_only_wd, out_valid_r && res_r.ev != idfr_pkg::EV_WATCHDOG |-> res_r.lost == '0, "lost zones outside report")
  `IDFR_ASSERT(a_wd_clears, accept && in_op == idfr_pkg::OP_TICK && wd_fire |=> alive_r == '0 && tick_r == '0, "watchdog did not clear")
  `IDFR_ASSERT(a_data_ends_pause, accept && in_op == idfr_pkg::OP_BYTE && in_rx_byte != delim_r |=> !pause_r, "pause kept after data")

endmodule

[sim/frame_result_checker.sv]
// result checker for the idle delimited frame receiver testbench
// depends on idfr_pkg; watches request, result and register ports, keeps its own frame state
module frame_result_checker
  import idfr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    in_op,
  input  logic [7:0]              in_rx_byte,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [2:0]              out_event_res,
  input  logic [ZONE_OUT_W-1:0]   out_zone,
  input  logic [7:0]              out_mode_flags,
  input  logic [7:0]              out_flag_r,
  input  logic [7:0]              out_flag_e,
  input  logic [7:0]              out_phase,
  input  logic [7:0]              out_regen_work_enable,
  input  logic [7:0]              out_regen_error,
  input  logic [7:0]              out_current,
  input  logic [7:0]              out_voltage,
  input  logic [7:0]              out_spark_count,
  input  logic [LOST_W-1:0]       out_lost_zones,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  output int unsigned             fail_count,
  output int unsigned             open_count,
  output int unsigned             results_seen,
  output int unsigned             frames_good,
  output int unsigned             frames_bad_sum,
  output int unsigned             frames_off_range,
  output int unsigned             watchdog_reports
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ev_code_t                ev;
    logic [ZONE_OUT_W-1:0]   zone;
    logic [8:0][7:0]         rec;
    logic [LOST_W-1:0]       lost;
  } frame_result_t;

  // receiver state as the block should hold it
  logic [7:0]          frame_buf [BUFFER_DEPTH];
  int unsigned         fill_idx;
  bit                  in_pause;
  logic [ZONES-1:0]    alive;
  logic [PERIOD_W-1:0] tick_cnt;
  logic [PERIOD_W-1:0] wd_period;
  logic [7:0]          delim;

  frame_result_t       awaited_results [$];
  frame_result_t       want;
  logic [8:0][7:0]     got_rec;

  string rec_names [9] = '{"mode_flags", "flag_r", "flag_e", "phase", "regen_work_enable",
                           "regen_error", "current", "voltage", "spark_count"};

  assign got_rec = {out_spark_count, out_voltage, out_current, out_regen_error,
                    out_regen_work_enable, out_phase, out_flag_e, out_flag_r, out_mode_flags};

  function automatic void clear_receiver();
    for (int k = 0; k < BUFFER_DEPTH; k++) frame_buf[k] = '0;
    fill_idx  = 0;
    in_pause  = 1'b0;
    alive     = '0;
    tick_cnt  = '0;
    wd_period = PERIOD_RESET;
    delim     = DELIM_RESET;
  endfunction

  function automatic frame_result_t advance_receiver(logic op, logic [7:0] b);
    frame_result_t r;
    logic [7:0]    sum;
    logic [3:0]    nib;
    r = '0;
    if (op == OP_TICK) begin
      if (tick_cnt >= wd_period) begin
        tick_cnt = '0;
        r.ev     = EV_WATCHDOG;
        r.lost   = LOST_W'(~alive);
        alive    = '0;
      end else begin
        tick_cnt = tick_cnt + 1'b1;
      end
    end else if (b != delim) begin
      in_pause = 1'b0;
      // bytes past the end of the buffer are lost
      if (fill_idx < BUFFER_DEPTH) begin
        frame_buf[fill_idx] = b;
        fill_idx++;
      end
    end else if (!in_pause) begin
      in_pause = 1'b1;
      fill_idx = 0;
      sum = '0;
      for (int k = 0; k < SUM_LEN; k++) sum += frame_buf[k];
      nib = frame_buf[0][7:4];
      if (sum != frame_buf[SUM_POS]) begin
        r.ev = EV_MISMATCH;
      end else if (nib == 0 || nib > ZONES) begin
        r.ev = EV_RANGE;
      end else begin
        alive[nib - 1] = 1'b1;
        r.ev   = EV_PACKET;
        r.zone = ZONE_OUT_W'(nib - 1);
        for (int k = REC_FIRST; k <= REC_LAST; k++) r.rec[k - 1] = frame_buf[k];
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_receiver();
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("result with nothing outstanding: event_res %0d", out_event_res);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("event_res", want.ev, out_event_res);
          check_field("zone", want.zone, out_zone);
          for (int k = 0; k < 9; k++) check_field(rec_names[k], want.rec[k], got_rec[k]);
          check_field("lost_zones", want.lost, out_lost_zones);
          case (want.ev)
            EV_PACKET:   frames_good++;
            EV_MISMATCH: frames_bad_sum++;
            EV_RANGE:    frames_off_range++;
            EV_WATCHDOG: watchdog_reports++;
            default: ;
          endcase
        end
      end
      if (in_valid && in_ready) awaited_results.push_back(advance_receiver(in_op, in_rx_byte));
      if (cfg_we) begin
        case (cfg_index)
          CFG_WATCHDOG_PERIOD: wd_period = cfg_wdata[PERIOD_W-1:0];
          CFG_DELIMITER_BYTE:  delim     = cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
    open_count <= awaited_results.size();
  end

endmodule

[sim/idle_delimited_frame_receiver_tb.sv]
// top of the idle delimited frame receiver testbench: clock, reset, stimulus, verdict
// depends on idfr_pkg, idle_delimited_frame_receiver and frame_result_checker
module idle_delimited_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import idfr_pkg::*;

  localparam int REQUESTS_TOTAL = 500;
  localparam int PHASES         = 6;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_op;
  logic [7:0]              in_rx_byte;
  logic                    out_valid;
  logic                    out_ready;
  logic [2:0]              out_event_res;
  logic [ZONE_OUT_W-1:0]   out_zone;
  logic [7:0]              out_mode_flags;
  logic [7:0]              out_flag_r;
  logic [7:0]              out_flag_e;
  logic [7:0]              out_phase;
  logic [7:0]              out_regen_work_enable;
  logic [7:0]              out_regen_error;
  logic [7:0]              out_current;
  logic [7:0]              out_voltage;
  logic [7:0]              out_spark_count;
  logic [LOST_W-1:0]       out_lost_zones;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  int unsigned fail_count;
  int unsigned open_count;
  int unsigned results_seen;
  int unsigned frames_good;
  int unsigned frames_bad_sum;
  int unsigned frames_off_range;
  int unsigned watchdog_reports;

  // stimulus bookkeeping
  int unsigned requests_sent;
  logic [7:0]  cur_delim;
  logic        steady;      // no idling on either side while set
  int          ready_hold;
  int          stall_len;

  idle_delimited_frame_receiver i_dut (.*);

  frame_result_checker i_checker (.*);

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // gap lengths: mostly none, often short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side back-pressure: random stretches of ready high and low
  always @(posedge clk) begin
    if (!rst_n || steady) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      stall_len = pick_gap();
      if (stall_len != 0) begin
        out_ready  <= 1'b0;
        ready_hold <= stall_len - 1;
      end else begin
        ready_hold <= $urandom_range(0, 6);
      end
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 8);
    end
  end

  // present one request and hold it until the block takes it
  task automatic push_request(logic op, logic [7:0] b);
    in_valid   <= 1'b1;
    in_op      <= op;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // one request followed by a random idle gap; valid stays up when the gap is zero
  task automatic send(logic op, logic [7:0] b);
    int g;
    push_request(op, b);
    g = pick_gap();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // stop sending and wait until every result is back and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // both registers are written back to back while the block is idle
  task automatic program_regs(logic [PERIOD_W-1:0] period, logic [7:0] delim);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WATCHDOG_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_index <= CFG_DELIMITER_BYTE;
    // upper data bits are noise, only the low byte belongs to the delimiter
    cfg_wdata <= {8'($urandom), delim};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_delim = delim;
  endtask

  function automatic logic [7:0] any_but_delim();
    logic [7:0] b;
    do b = 8'($urandom); while (b == cur_delim);
    return b;
  endfunction

  // builds a frame with zone nibble nib, sends len bytes of it and then the closers;
  // ticks are sprinkled between bytes since they must not disturb framing
  task automatic send_frame(logic [3:0] nib, bit bad_sum, int len, int closers);
    logic [7:0] fr [20];
    logic [7:0] sum;
    fr[0] = {nib, 4'($urandom)};
    if (fr[0] == cur_delim) fr[0][0] = ~fr[0][0];
    for (int k = 1; k < 20; k++) fr[k] = any_but_delim();
    // a checksum equal to the delimiter would split the frame, so reroll the last record byte
    do begin
      fr[9] = any_but_delim();
      sum = '0;
      for (int k = 0; k < SUM_LEN; k++) sum += fr[k];
      if (bad_sum) sum += 8'($urandom_range(1, 255));
    end while (sum == cur_delim);
    fr[SUM_POS] = sum;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 15) send(OP_TICK, 8'($urandom));
      send(OP_BYTE, fr[k]);
    end
    repeat (closers) send(OP_BYTE, cur_delim);
  endtask

  // mostly well formed frames, some with a bad zone or checksum, odd lengths or no closer
  task automatic random_frame();
    logic [3:0] nib;
    int         r;
    int         len;
    int         closers;
    r = $urandom_range(0, 11);
    if ($urandom_range(0, 99) < 85) nib = 4'($urandom_range(1, ZONES));
    else nib = (r == 0) ? 4'd0 : 4'(r + ZONES);
    r = $urandom_range(0, 99);
    if (r < 80) len = SUM_POS + 1;
    else if (r < 90) len = $urandom_range(1, SUM_POS);
    else len = $urandom_range(SUM_POS + 2, 20);
    r = $urandom_range(0, 99);
    closers = (r < 5) ? 0 : (r < 25) ? 2 : 1;
    send_frame(nib, $urandom_range(0, 9) == 0, len, closers);
  endtask

  initial begin
    logic [7:0]  probe [SUM_POS + 1];
    logic [7:0]  b;
    int unsigned phase_goal;
    int          pick;
    bit          paused;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_op      = OP_BYTE;
    in_rx_byte = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_WATCHDOG_PERIOD;
    cfg_wdata  = '0;
    cur_delim  = DELIM_RESET;
    steady     = 1'b0;
    requests_sent = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, register defaults
    // delimiter right after reset checks the cleared buffer: sum matches, zone underflows
    send(OP_BYTE, DELIM_RESET);
    // a second delimiter in a row is ignored
    send(OP_BYTE, DELIM_RESET);
    send(OP_TICK, 8'hFF);
    send(OP_TICK, 8'h00);
    // full frame for the top zone, record bytes at the extremes
    probe = '{8'h4F, 8'h00, 8'hFE, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h00, 8'h55, 8'hAA, 8'h00};
    for (int k = 0; k < SUM_LEN; k++) probe[SUM_POS] += probe[k];
    foreach (probe[k]) send(OP_BYTE, probe[k]);
    send(OP_BYTE, DELIM_RESET);
    // one byte frames lean on the stale buffer: same first byte passes, another fails
    send(OP_BYTE, 8'h4F);
    send(OP_BYTE, DELIM_RESET);
    send(OP_BYTE, 8'h10);
    send(OP_BYTE, DELIM_RESET);
    send(OP_BYTE, DELIM_RESET);

    // random part, one register setting per phase
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: program_regs(16'd1, 8'h00);
        1: program_regs(16'($urandom_range(3, 20)), 8'hFF);
        2: program_regs(16'hFFFF, 8'($urandom));
        3: program_regs(16'($urandom_range(2, 12)), 8'hFF);
        4: program_regs(PERIOD_RESET, 8'($urandom));
        default: program_regs(16'($urandom_range(1, 6)), 8'hA5);
      endcase
      // one phase runs flat out with no idling at all
      steady <= (phase == 3);
      phase_goal = requests_sent + REQUESTS_TOTAL / PHASES;
      paused = 0;
      while (requests_sent < phase_goal) begin
        // hold the sender once per phase until the result side has caught up
        if (!paused && requests_sent + 40 > phase_goal) begin
          settle();
          paused = 1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          random_frame();
        end else if (pick < 90) begin
          // noise: loose bytes, ticks and stray delimiters
          repeat ($urandom_range(1, 8)) begin
            b = ($urandom_range(0, 3) == 0) ? cur_delim : 8'($urandom);
            send(($urandom_range(0, 3) == 0) ? OP_TICK : OP_BYTE, b);
          end
        end else begin
          repeat ($urandom_range(1, 15)) send(OP_TICK, 8'($urandom));
        end
      end
    end

    settle();
    repeat (4) @(posedge clk);
    $display("run covered %0d requests and %0d results across %0d register settings",
             requests_sent, results_seen, PHASES + 1);
    $display("%0d frames taken, %0d checksum errors, %0d zones out of range, %0d watchdog reports",
             frames_good, frames_bad_sum, frames_off_range, watchdog_reports);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[idle_delimited_frame_receiver.f]
+incdir+sv
sv/idfr_pkg.sv
sv/idle_delimited_frame_receiver.sv
sim/frame_result_checker.sv
sim/idle_delimited_frame_receiver_tb.sv
